FILE: hw/rtl/mwu_pkg.sv
// Shared types and codes for the memory watchpoint unit.
// No dependencies; every other file of the block imports this package.
package mwu_pkg;

   // Field widths fixed by the request and response formats
   localparam int FUNC_W  = 3;
   localparam int ADDR_W  = 32;
   localparam int VALUE_W = 8;
   localparam int SLOT_W  = 3;
   localparam int SIZE_W  = 32;
   localparam int MODE_W  = 2;
   localparam int TICK_W  = 32;
   localparam int COUNT_W = 32;

   // Request function codes
   localparam logic [FUNC_W-1:0] FUNC_READ       = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_WRITE      = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_TICK       = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_RESET_TICK = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_SET_SLOT   = 3'd4;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR_SLOT = 3'd5;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR_ALL  = 3'd6;
   localparam logic [FUNC_W-1:0] FUNC_POP        = 3'd7;

   // Mode bits of a watch slot
   localparam int MODE_RD_BIT = 0;
   localparam int MODE_WR_BIT = 1;

   // Classified request handed from front to back end
   typedef struct packed {
      logic [FUNC_W-1:0]  func;
      logic [ADDR_W-1:0]  addr;
      logic [VALUE_W-1:0] value;
      logic [TICK_W-1:0]  tick;
   } mwu_cmd_type;

   // One hit log entry
   typedef struct packed {
      logic [ADDR_W-1:0]  addr;
      logic [VALUE_W-1:0] value;
      logic [TICK_W-1:0]  tick;
      logic               was_write;
      logic [SLOT_W-1:0]  slot;
   } mwu_log_type;

endpackage

FILE: hw/rtl/mwu_front.sv
// Front end: watch slot registers, tick counter and parallel range compare.
// Depends on mwu_pkg.
module mwu_front import mwu_pkg::*; #(
   parameter int WATCH_SLOTS = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic [FUNC_W-1:0]      func,
   input  logic [ADDR_W-1:0]      addr,
   input  logic [VALUE_W-1:0]     value,
   input  logic [SLOT_W-1:0]      slot,
   input  logic [SIZE_W-1:0]      size,
   input  logic [MODE_W-1:0]      mode,
   output mwu_cmd_type            cmd,
   output logic [WATCH_SLOTS-1:0] hit_mask
);

   logic [ADDR_W-1:0]      start_ff  [WATCH_SLOTS];
   logic [ADDR_W-1:0]      start_in  [WATCH_SLOTS];
   logic [ADDR_W-1:0]      end_ff    [WATCH_SLOTS];
   logic [ADDR_W-1:0]      end_in    [WATCH_SLOTS];
   logic [MODE_W-1:0]      mode_ff   [WATCH_SLOTS];
   logic [MODE_W-1:0]      mode_in   [WATCH_SLOTS];
   logic [WATCH_SLOTS-1:0] enabled_ff;
   logic [WATCH_SLOTS-1:0] enabled_in;
   logic [TICK_W-1:0]      tick_ff;
   logic [TICK_W-1:0]      tick_in;
   logic                   is_read;
   logic                   acc_write;

   // Range compare: the end address is precomputed (wrapping) when a slot is set,
   // so a wrapped or empty range never satisfies start <= addr < end
   always_comb begin
      is_read   = (func == FUNC_READ);
      acc_write = (func == FUNC_WRITE);
      for (int i = 0; i < WATCH_SLOTS; i++) begin
         hit_mask[i] = enabled_ff[i]
                       && ((is_read && mode_ff[i][MODE_RD_BIT])
                           || (acc_write && mode_ff[i][MODE_WR_BIT]))
                       && (addr >= start_ff[i]) && (addr < end_ff[i]);
      end
   end

   // Request as seen by the back end; tick is sampled before this request's update
   always_comb begin
      cmd.func  = func;
      cmd.addr  = addr;
      cmd.value = value;
      cmd.tick  = tick_ff;
   end

   // Slot and tick updates
   always_comb begin
      start_in   = start_ff;
      end_in     = end_ff;
      mode_in    = mode_ff;
      enabled_in = enabled_ff;
      tick_in    = tick_ff;
      if (accept) begin
         case (func)
            FUNC_TICK: begin
               tick_in = tick_ff + TICK_W'(1);
            end
            FUNC_RESET_TICK: begin
               tick_in = '0;
            end
            FUNC_SET_SLOT: begin
               for (int i = 0; i < WATCH_SLOTS; i++) begin
                  if (int'(slot) == i) begin
                     start_in[i]   = addr;
                     end_in[i]     = addr + size;
                     mode_in[i]    = mode;
                     enabled_in[i] = 1'b1;
                  end
               end
            end
            FUNC_CLEAR_SLOT: begin
               for (int i = 0; i < WATCH_SLOTS; i++) begin
                  if (int'(slot) == i) begin
                     enabled_in[i] = 1'b0;
                  end
               end
            end
            FUNC_CLEAR_ALL: begin
               enabled_in = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff <= '0;
         tick_ff    <= '0;
      end else begin
         enabled_ff <= enabled_in;
         tick_ff    <= tick_in;
      end
   end

   // Slot payload; only meaningful while the slot is enabled
   always_ff @(posedge clock) begin
      start_ff <= start_in;
      end_ff   <= end_in;
      mode_ff  <= mode_in;
   end

endmodule

FILE: hw/rtl/mwu_queue.sv
// Two-entry request queue between front and back end.
// Depends on mwu_pkg.
module mwu_queue import mwu_pkg::*; #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             full,
   output logic             empty
);

   localparam int DEPTH = 2;

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic             wr_ptr_ff;
   logic             wr_ptr_in;
   logic             rd_ptr_ff;
   logic             rd_ptr_in;
   logic [1:0]       count_ff;
   logic [1:0]       count_in;

   assign full     = (count_ff == 2'(DEPTH));
   assign empty    = (count_ff == 2'd0);
   assign pop_data = entry_ff[rd_ptr_ff];

   // Pointer and fill count
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: hw/rtl/mwu_back.sv
// Back end: hit log memory, log counters, per-slot log sequencing and response register.
// Depends on mwu_pkg.
module mwu_back import mwu_pkg::*; #(
   parameter int WATCH_SLOTS   = 8,
   parameter int HIT_LOG_DEPTH = 256
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_empty,
   input  mwu_cmd_type            q_cmd,
   input  logic [WATCH_SLOTS-1:0] q_mask,
   output logic                   q_pop,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_hit_valid,
   output logic [ADDR_W-1:0]      rsp_hit_addr,
   output logic [VALUE_W-1:0]     rsp_hit_value,
   output logic [TICK_W-1:0]      rsp_hit_tick,
   output logic                   rsp_hit_is_write,
   output logic [SLOT_W-1:0]      rsp_hit_slot
);

   localparam int IDX_W = $clog2(HIT_LOG_DEPTH);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_LOG  = 2'd1;
   localparam logic [1:0] ST_POP  = 2'd2;

   logic [1:0]             state_ff;
   logic [1:0]             state_in;
   mwu_cmd_type            cur_ff;
   mwu_cmd_type            cur_in;
   logic [WATCH_SLOTS-1:0] mask_ff;
   logic [WATCH_SLOTS-1:0] mask_in;
   logic [COUNT_W-1:0]     wr_count_ff;
   logic [COUNT_W-1:0]     wr_count_in;
   logic [COUNT_W-1:0]     rd_count_ff;
   logic [COUNT_W-1:0]     rd_count_in;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   mwu_log_type            rsp_ff;
   mwu_log_type            rsp_in;
   logic                   rsp_hit_ff;
   logic                   rsp_hit_in;

   mwu_log_type            log_mem [HIT_LOG_DEPTH];
   mwu_log_type            rd_data_ff;
   mwu_log_type            wr_entry;
   logic                   wr_en;
   logic                   rd_en;
   logic [WATCH_SLOTS-1:0] lowest;
   logic [SLOT_W-1:0]      slot_code;
   logic                   out_free;
   logic                   load_zero;
   logic                   load_hit;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Lowest pending slot of the current access
   always_comb begin
      lowest    = mask_ff & (~mask_ff + WATCH_SLOTS'(1));
      slot_code = '0;
      for (int i = 0; i < WATCH_SLOTS; i++) begin
         if (lowest[i]) begin
            slot_code = slot_code | SLOT_W'(i);
         end
      end
      wr_entry.addr      = cur_ff.addr;
      wr_entry.value     = cur_ff.value;
      wr_entry.tick      = cur_ff.tick;
      wr_entry.was_write = (cur_ff.func == FUNC_WRITE);
      wr_entry.slot      = slot_code;
   end

   // Sequencer
   always_comb begin
      state_in    = state_ff;
      cur_in      = cur_ff;
      mask_in     = mask_ff;
      wr_count_in = wr_count_ff;
      rd_count_in = rd_count_ff;
      q_pop       = 1'b0;
      wr_en       = 1'b0;
      rd_en       = 1'b0;
      load_zero   = 1'b0;
      load_hit    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (!q_empty && out_free) begin
               q_pop = 1'b1;
               case (q_cmd.func)
                  FUNC_READ, FUNC_WRITE: begin
                     if (q_mask != '0) begin
                        cur_in   = q_cmd;
                        mask_in  = q_mask;
                        state_in = ST_LOG;
                     end else begin
                        load_zero = 1'b1;
                     end
                  end
                  FUNC_POP: begin
                     if (rd_count_ff != wr_count_ff) begin
                        rd_en       = 1'b1;
                        rd_count_in = rd_count_ff + COUNT_W'(1);
                        state_in    = ST_POP;
                     end else begin
                        load_zero = 1'b1;
                     end
                  end
                  FUNC_CLEAR_ALL: begin
                     wr_count_in = '0;
                     rd_count_in = '0;
                     load_zero   = 1'b1;
                  end
                  default: begin
                     load_zero = 1'b1;
                  end
               endcase
            end
         end
         ST_LOG: begin
            // one log append per cycle, lowest slot first
            if (mask_ff != '0) begin
               wr_en       = 1'b1;
               wr_count_in = wr_count_ff + COUNT_W'(1);
               mask_in     = mask_ff & ~lowest;
            end else if (out_free) begin
               load_zero = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         ST_POP: begin
            if (out_free) begin
               load_hit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_hit_in   = rsp_hit_ff;
      rsp_in       = rsp_ff;
      if (load_zero) begin
         rsp_valid_in = 1'b1;
         rsp_hit_in   = 1'b0;
         rsp_in       = '0;
      end else if (load_hit) begin
         rsp_valid_in = 1'b1;
         rsp_hit_in   = 1'b1;
         rsp_in       = rd_data_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wr_count_ff  <= '0;
         rd_count_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         rsp_hit_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wr_count_ff  <= wr_count_in;
         rd_count_ff  <= rd_count_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_hit_ff   <= rsp_hit_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      mask_ff <= mask_in;
      rsp_ff  <= rsp_in;
   end

   // Hit log memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         log_mem[wr_count_ff[IDX_W-1:0]] <= wr_entry;
      end
      if (rd_en) begin
         rd_data_ff <= log_mem[rd_count_ff[IDX_W-1:0]];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_hit_valid    = rsp_hit_ff;
   assign rsp_hit_addr     = rsp_ff.addr;
   assign rsp_hit_value    = rsp_ff.value;
   assign rsp_hit_tick     = rsp_ff.tick;
   assign rsp_hit_is_write = rsp_ff.was_write;
   assign rsp_hit_slot     = rsp_ff.slot;

endmodule

FILE: hw/rtl/memory_watchpoint_unit_core.sv
// Memory watchpoint unit top level: front end, request queue and back end.
// Depends on mwu_pkg, mwu_front, mwu_queue, mwu_back.
//
//   channel   direction  handshake              payload
//   req_*     in         req_valid / req_stall  func addr value slot size mode
//   rsp_*     out        rsp_valid / rsp_stall  hit_valid hit_addr hit_value
//                                               hit_tick hit_is_write hit_slot
//
// Each request gives one response. Slot and tick requests, accesses that
// match no slot and pops from an empty log are answered straight from the
// idle state; an access that matches slots appends one log entry per matching
// slot (serialized on the single log memory write port), then loads the
// response; a pop that returns an entry does a registered memory read first,
// then loads the response. The front end compares all slots in the accept
// cycle; a two-entry queue lets it keep accepting while the back end works.
// Reset is synchronous; the log memory is not cleared, the counters are.
// HIT_LOG_DEPTH must be a power of two. rsp_stall holds the response register.
module memory_watchpoint_unit_core import mwu_pkg::*; #(
   parameter int WATCH_SLOTS   = 8,
   parameter int HIT_LOG_DEPTH = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [FUNC_W-1:0]  req_func,
   input  logic [ADDR_W-1:0]  req_addr,
   input  logic [VALUE_W-1:0] req_value,
   input  logic [SLOT_W-1:0]  req_slot,
   input  logic [SIZE_W-1:0]  req_size,
   input  logic [MODE_W-1:0]  req_mode,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_hit_valid,
   output logic [ADDR_W-1:0]  rsp_hit_addr,
   output logic [VALUE_W-1:0] rsp_hit_value,
   output logic [TICK_W-1:0]  rsp_hit_tick,
   output logic               rsp_hit_is_write,
   output logic [SLOT_W-1:0]  rsp_hit_slot
);

   localparam int CMD_W = $bits(mwu_cmd_type);
   localparam int Q_W   = CMD_W + WATCH_SLOTS;

   logic                   accept;
   logic                   q_full;
   logic                   q_empty;
   logic                   q_pop;
   mwu_cmd_type            front_cmd;
   logic [WATCH_SLOTS-1:0] front_mask;
   logic [Q_W-1:0]         q_data;
   mwu_cmd_type            q_cmd;
   logic [WATCH_SLOTS-1:0] q_mask;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   mwu_front #(
      .WATCH_SLOTS(WATCH_SLOTS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .func     (req_func),
      .addr     (req_addr),
      .value    (req_value),
      .slot     (req_slot),
      .size     (req_size),
      .mode     (req_mode),
      .cmd      (front_cmd),
      .hit_mask (front_mask)
   );

   mwu_queue #(
      .WIDTH(Q_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data ({front_mask, front_cmd}),
      .pop       (q_pop),
      .pop_data  (q_data),
      .full      (q_full),
      .empty     (q_empty)
   );

   assign q_cmd  = mwu_cmd_type'(q_data[CMD_W-1:0]);
   assign q_mask = q_data[Q_W-1:CMD_W];

   mwu_back #(
      .WATCH_SLOTS   (WATCH_SLOTS),
      .HIT_LOG_DEPTH (HIT_LOG_DEPTH)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_empty          (q_empty),
      .q_cmd            (q_cmd),
      .q_mask           (q_mask),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_hit_valid    (rsp_hit_valid),
      .rsp_hit_addr     (rsp_hit_addr),
      .rsp_hit_value    (rsp_hit_value),
      .rsp_hit_tick     (rsp_hit_tick),
      .rsp_hit_is_write (rsp_hit_is_write),
      .rsp_hit_slot     (rsp_hit_slot)
   );

endmodule

FILE: hw/rtl/mwu_checker.sv
// Port-level checks for the memory watchpoint unit, bound to the top level.
// Depends on mwu_pkg and memory_watchpoint_unit_core.
module mwu_checker import mwu_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic               rsp_hit_valid,
   input logic [ADDR_W-1:0]  rsp_hit_addr,
   input logic [VALUE_W-1:0] rsp_hit_value,
   input logic [TICK_W-1:0]  rsp_hit_tick,
   input logic               rsp_hit_is_write,
   input logic [SLOT_W-1:0]  rsp_hit_slot
);

   logic [7:0] pending_ff;
   logic [7:0] pending_in;

   // Requests accepted but not yet answered
   always_comb begin
      pending_in = pending_ff;
      if (req_valid && !req_stall) begin
         pending_in = pending_in + 8'd1;
      end
      if (rsp_valid && !rsp_stall) begin
         pending_in = pending_in - 8'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // No response without an outstanding request
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (pending_ff != 8'd0))
      else $error("response without outstanding request");

   // A response without a hit carries all-zero fields
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_hit_valid) |-> (rsp_hit_addr == '0 && rsp_hit_value == '0
         && rsp_hit_tick == '0 && !rsp_hit_is_write && rsp_hit_slot == '0))
      else $error("non-hit response with nonzero fields");

   // A stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_hit_valid)
         && $stable(rsp_hit_addr) && $stable(rsp_hit_tick) && $stable(rsp_hit_slot)))
      else $error("stalled response changed");

   // Reset leaves no response pending
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind memory_watchpoint_unit_core mwu_checker u_mwu_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_hit_valid    (rsp_hit_valid),
   .rsp_hit_addr     (rsp_hit_addr),
   .rsp_hit_value    (rsp_hit_value),
   .rsp_hit_tick     (rsp_hit_tick),
   .rsp_hit_is_write (rsp_hit_is_write),
   .rsp_hit_slot     (rsp_hit_slot)
);

FILE: sim/mwu_hit_checker.sv
// Response checker for the memory watchpoint unit: it follows the accepted
// requests, predicts each response and compares it with the unit's output.
// Depends on mwu_pkg; instantiated beside the unit by the testbench top.
module mwu_hit_checker import mwu_pkg::*; #(
   parameter int WATCH_SLOTS   = 8,
   parameter int HIT_LOG_DEPTH = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [FUNC_W-1:0]  req_func,
   input  logic [ADDR_W-1:0]  req_addr,
   input  logic [VALUE_W-1:0] req_value,
   input  logic [SLOT_W-1:0]  req_slot,
   input  logic [SIZE_W-1:0]  req_size,
   input  logic [MODE_W-1:0]  req_mode,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic               rsp_hit_valid,
   input  logic [ADDR_W-1:0]  rsp_hit_addr,
   input  logic [VALUE_W-1:0] rsp_hit_value,
   input  logic [TICK_W-1:0]  rsp_hit_tick,
   input  logic               rsp_hit_is_write,
   input  logic [SLOT_W-1:0]  rsp_hit_slot,
   output int                 mismatch_count,
   output int                 pending_count,
   output int                 responses_seen,
   output int                 hits_returned,
   output int                 overwrites
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDX_W = $clog2(HIT_LOG_DEPTH);

   typedef struct packed {
      logic               valid;
      logic [ADDR_W-1:0]  addr;
      logic [VALUE_W-1:0] value;
      logic [TICK_W-1:0]  tick;
      logic               was_write;
      logic [SLOT_W-1:0]  slot;
   } hit_rsp_type;

   // Shadow of the watch slots, the hit log and the counters
   logic [ADDR_W-1:0]  watch_start [WATCH_SLOTS];
   logic [SIZE_W-1:0]  watch_size  [WATCH_SLOTS];
   logic [MODE_W-1:0]  watch_mode  [WATCH_SLOTS];
   logic               watch_on    [WATCH_SLOTS];
   mwu_log_type        hit_log     [HIT_LOG_DEPTH];
   logic [COUNT_W-1:0] log_wr_count;
   logic [COUNT_W-1:0] log_rd_count;
   logic [TICK_W-1:0]  tick_now;
   hit_rsp_type        expected_hits [$];

   // One log entry per matching slot, lowest slot first
   task automatic log_access(input logic acc_write);
      logic [ADDR_W-1:0] range_end;
      for (int i = 0; i < WATCH_SLOTS; i++) begin
         range_end = watch_start[i] + watch_size[i];
         if (watch_on[i] && watch_mode[i][acc_write ? MODE_WR_BIT : MODE_RD_BIT] &&
             req_addr >= watch_start[i] && req_addr < range_end) begin
            // unread entry about to be replaced
            if (log_wr_count - log_rd_count >= COUNT_W'(HIT_LOG_DEPTH)) overwrites++;
            hit_log[log_wr_count[IDX_W-1:0]] = '{addr: req_addr, value: req_value,
                                                 tick: tick_now, was_write: acc_write,
                                                 slot: SLOT_W'(i)};
            log_wr_count = log_wr_count + COUNT_W'(1);
         end
      end
   endtask

   // Update the shadow state for one accepted request and queue its response
   task automatic predict_request();
      hit_rsp_type want;
      mwu_log_type entry;
      want = '0;
      case (req_func)
         FUNC_READ:       log_access(1'b0);
         FUNC_WRITE:      log_access(1'b1);
         FUNC_TICK:       tick_now = tick_now + TICK_W'(1);
         FUNC_RESET_TICK: tick_now = '0;
         FUNC_SET_SLOT: begin
            if (req_slot < WATCH_SLOTS) begin
               watch_start[req_slot] = req_addr;
               watch_size[req_slot]  = req_size;
               watch_mode[req_slot]  = req_mode;
               watch_on[req_slot]    = 1'b1;
            end
         end
         FUNC_CLEAR_SLOT: begin
            if (req_slot < WATCH_SLOTS) watch_on[req_slot] = 1'b0;
         end
         FUNC_CLEAR_ALL: begin
            foreach (watch_on[i]) watch_on[i] = 1'b0;
            log_wr_count = '0;
            log_rd_count = '0;
         end
         FUNC_POP: begin
            if (log_rd_count != log_wr_count) begin
               entry = hit_log[log_rd_count[IDX_W-1:0]];
               log_rd_count   = log_rd_count + COUNT_W'(1);
               want.valid     = 1'b1;
               want.addr      = entry.addr;
               want.value     = entry.value;
               want.tick      = entry.tick;
               want.was_write = entry.was_write;
               want.slot      = entry.slot;
            end
         end
         default: ;
      endcase
      expected_hits.push_back(want);
   endtask

   // Count and, for the first few, report one differing field
   task automatic note_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
      if (got !== want) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("ERROR: response %0d %s expected 0x%0h got 0x%0h",
                     responses_seen, name, want, got);
      end
   endtask

   task automatic check_response();
      hit_rsp_type want;
      if (expected_hits.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("ERROR: response %0d arrived with no request waiting", responses_seen);
      end else begin
         want = expected_hits.pop_front();
         note_field("hit_valid",    32'(want.valid),     32'(rsp_hit_valid));
         note_field("hit_addr",     32'(want.addr),      32'(rsp_hit_addr));
         note_field("hit_value",    32'(want.value),     32'(rsp_hit_value));
         note_field("hit_tick",     32'(want.tick),      32'(rsp_hit_tick));
         note_field("hit_is_write", 32'(want.was_write), 32'(rsp_hit_is_write));
         note_field("hit_slot",     32'(want.slot),      32'(rsp_hit_slot));
         if (want.valid) hits_returned++;
      end
      responses_seen++;
   endtask

   // Sample both channels at the rising edge
   always @(posedge clock) begin
      if (reset) begin
         foreach (watch_on[i]) begin
            watch_start[i] = '0;
            watch_size[i]  = '0;
            watch_mode[i]  = '0;
            watch_on[i]    = 1'b0;
         end
         log_wr_count = '0;
         log_rd_count = '0;
         tick_now     = '0;
         expected_hits.delete();
      end else begin
         if (rsp_valid && !rsp_stall) check_response();
         if (req_valid && !req_stall) predict_request();
      end
      pending_count = expected_hits.size();
   end

endmodule

FILE: sim/tb_memory_watchpoint_unit_core.sv
// Testbench top for memory_watchpoint_unit_core: clock, reset, request
// stimulus, response stalls and the verdict. Depends on mwu_pkg, the unit's
// RTL and mwu_hit_checker, which predicts and compares the responses.
module tb_memory_watchpoint_unit_core import mwu_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCH_SLOTS   = 8;
   localparam int HIT_LOG_DEPTH = 256;
   localparam int HOLD_CYCLES   = 300;

   logic               clock = 1'b0;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [FUNC_W-1:0]  req_func;
   logic [ADDR_W-1:0]  req_addr;
   logic [VALUE_W-1:0] req_value;
   logic [SLOT_W-1:0]  req_slot;
   logic [SIZE_W-1:0]  req_size;
   logic [MODE_W-1:0]  req_mode;
   logic               rsp_valid;
   logic               rsp_stall;
   logic               rsp_hit_valid;
   logic [ADDR_W-1:0]  rsp_hit_addr;
   logic [VALUE_W-1:0] rsp_hit_value;
   logic [TICK_W-1:0]  rsp_hit_tick;
   logic               rsp_hit_is_write;
   logic [SLOT_W-1:0]  rsp_hit_slot;

   int mismatch_count;
   int pending_count;
   int responses_seen;
   int hits_returned;
   int overwrites;

   int requests_sent = 0;
   int burst_left    = 0;
   int hold_asked    = 0;
   int hold_given    = 0;

   // Slot ranges as last set, used only to aim accesses at watched bytes
   logic [ADDR_W-1:0] aim_start [WATCH_SLOTS];
   logic [SIZE_W-1:0] aim_size  [WATCH_SLOTS];
   logic              aim_live  [WATCH_SLOTS];

   always #4 clock = ~clock;

   memory_watchpoint_unit_core #(
      .WATCH_SLOTS   (WATCH_SLOTS),
      .HIT_LOG_DEPTH (HIT_LOG_DEPTH)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_addr         (req_addr),
      .req_value        (req_value),
      .req_slot         (req_slot),
      .req_size         (req_size),
      .req_mode         (req_mode),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_hit_valid    (rsp_hit_valid),
      .rsp_hit_addr     (rsp_hit_addr),
      .rsp_hit_value    (rsp_hit_value),
      .rsp_hit_tick     (rsp_hit_tick),
      .rsp_hit_is_write (rsp_hit_is_write),
      .rsp_hit_slot     (rsp_hit_slot)
   );

   mwu_hit_checker #(
      .WATCH_SLOTS   (WATCH_SLOTS),
      .HIT_LOG_DEPTH (HIT_LOG_DEPTH)
   ) hit_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_addr         (req_addr),
      .req_value        (req_value),
      .req_slot         (req_slot),
      .req_size         (req_size),
      .req_mode         (req_mode),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_hit_valid    (rsp_hit_valid),
      .rsp_hit_addr     (rsp_hit_addr),
      .rsp_hit_value    (rsp_hit_value),
      .rsp_hit_tick     (rsp_hit_tick),
      .rsp_hit_is_write (rsp_hit_is_write),
      .rsp_hit_slot     (rsp_hit_slot),
      .mismatch_count   (mismatch_count),
      .pending_count    (pending_count),
      .responses_seen   (responses_seen),
      .hits_returned    (hits_returned),
      .overwrites       (overwrites)
   );

   // Offer one request; bursts of random length with random gaps between.
   // Called and returns at a falling edge.
   task automatic send(input logic [FUNC_W-1:0] func, input logic [ADDR_W-1:0] addr,
                       input logic [VALUE_W-1:0] value, input logic [SLOT_W-1:0] slot,
                       input logic [SIZE_W-1:0] size, input logic [MODE_W-1:0] mode);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                  : $urandom_range(1, 12);
      end
      req_valid <= 1'b1;
      req_func  <= func;
      req_addr  <= addr;
      req_value <= value;
      req_slot  <= slot;
      req_size  <= size;
      req_mode  <= mode;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      burst_left--;
      requests_sent++;
   endtask

   // Request whose only meaningful field is the function
   task automatic send_op(input logic [FUNC_W-1:0] func);
      send(func, $urandom, VALUE_W'($urandom), SLOT_W'($urandom), $urandom,
           MODE_W'($urandom));
   endtask

   task automatic send_set(input logic [SLOT_W-1:0] slot, input logic [ADDR_W-1:0] start,
                           input logic [SIZE_W-1:0] size, input logic [MODE_W-1:0] mode);
      aim_start[slot] = start;
      aim_size[slot]  = size;
      aim_live[slot]  = 1'b1;
      send(FUNC_SET_SLOT, start, VALUE_W'($urandom), slot, size, mode);
   endtask

   task automatic clear_all();
      foreach (aim_live[i]) aim_live[i] = 1'b0;
      send_op(FUNC_CLEAR_ALL);
   endtask

   // Mostly inside a watched range, sometimes on its edges or anywhere
   function automatic logic [ADDR_W-1:0] pick_addr();
      int s;
      s = $urandom_range(0, WATCH_SLOTS - 1);
      if (!aim_live[s] || $urandom_range(0, 7) == 0) return $urandom;
      case ($urandom_range(0, 9))
         0: return aim_start[s] + aim_size[s];
         1: return aim_start[s] - ADDR_W'(1);
         2: return aim_start[s];
         default: return aim_start[s] + ((aim_size[s] == 0) ? 0 : $urandom % aim_size[s]);
      endcase
   endfunction

   // Random slot setup: overlaps, empty ranges, wrapping ends, mode zero
   task automatic random_set();
      logic [SLOT_W-1:0] s;
      logic [SLOT_W-1:0] other;
      logic [ADDR_W-1:0] start;
      logic [SIZE_W-1:0] size;
      logic [MODE_W-1:0] mode;
      s     = SLOT_W'($urandom);
      other = SLOT_W'($urandom);
      start = (aim_live[other] && $urandom_range(0, 2) == 0)
              ? aim_start[other] + $urandom_range(0, 8) : $urandom;
      case ($urandom_range(0, 9))
         0:       size = '0;
         1:       size = $urandom;
         2:       size = -start;
         3:       size = 32'hFFFF_FFFF - start;
         default: size = $urandom_range(1, 256);
      endcase
      mode = ($urandom_range(0, 9) == 0) ? 2'd0 : MODE_W'($urandom_range(1, 3));
      send_set(s, start, size, mode);
   endtask

   // All slots on one range, many accesses with the receiver held off:
   // fills the unit, stalls its input and overruns the log
   task automatic flood(input int accesses);
      logic [ADDR_W-1:0] base;
      base = {16'($urandom_range(0, 16'hFFFE)), 16'h0000};
      for (int s = 0; s < WATCH_SLOTS; s++) send_set(SLOT_W'(s), base, 64, 2'b11);
      hold_asked++;
      repeat (accesses)
         send($urandom_range(0, 1) ? FUNC_WRITE : FUNC_READ, base + $urandom_range(0, 63),
              VALUE_W'($urandom), SLOT_W'($urandom), $urandom, MODE_W'($urandom));
      repeat (48) send_op(FUNC_POP);
   endtask

   // Receiver stalls: rotating pattern, plus a long hold-off on request
   initial begin
      int cyc;
      cyc = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_asked != hold_given) begin
            rsp_stall <= 1'b1;
            for (int n = 1; n < HOLD_CYCLES; n++) @(negedge clock);
            hold_given++;
         end else begin
            case ((cyc / 150) % 4)
               0:       rsp_stall <= 1'b0;
               1:       rsp_stall <= ($urandom_range(0, 99) < 30);
               2:       rsp_stall <= ($urandom_range(0, 99) < 75);
               default: rsp_stall <= ((cyc % 7) < 3);
            endcase
         end
         cyc++;
      end
   end

   initial begin
      #4_000_000;
      $display("Mismatches found");
      $finish;
   end

   initial begin
      int pick;
      bit flooded_mid;
      flooded_mid = 1'b0;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_func  = FUNC_READ;
      req_addr  = '0;
      req_value = '0;
      req_slot  = '0;
      req_size  = '0;
      req_mode  = '0;
      foreach (aim_live[i]) begin
         aim_start[i] = '0;
         aim_size[i]  = '0;
         aim_live[i]  = 1'b0;
      end
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: range edges, mode bits, empty and wrapping ranges, pops
      send_op(FUNC_POP);                                  // empty log
      send_set(3'd0, 32'h0000_0000, 32'h1, 2'b11);
      send_set(3'd7, 32'hFFFF_FF00, 32'h100, 2'b11);      // end wraps to zero
      send_set(3'd1, 32'h0000_1000, 32'h10, 2'b01);       // reads only
      send_set(3'd2, 32'h0000_1000, 32'h10, 2'b10);       // writes only
      send_set(3'd3, 32'h0000_1000, 32'h10, 2'b00);       // enabled, never matches
      send_set(3'd4, 32'h0000_1000, 32'h0, 2'b11);        // zero size
      send_set(3'd5, 32'hFFFF_FFF0, 32'hF, 2'b11);        // ends at the top
      send(FUNC_READ, 32'h0000_0000, 8'hFF, 3'd7, 32'hFFFF_FFFF, 2'b11);
      send(FUNC_WRITE, 32'h0000_1000, 8'h00, 3'd0, 32'h0, 2'b00);
      send(FUNC_READ, 32'h0000_100F, 8'hA5, 3'd0, 32'h0, 2'b00);
      send(FUNC_READ, 32'h0000_1010, 8'h5A, 3'd0, 32'h0, 2'b00);
      send(FUNC_WRITE, 32'hFFFF_FFFF, 8'h3C, 3'd0, 32'h0, 2'b00);
      send_op(FUNC_TICK);
      send(FUNC_WRITE, 32'hFFFF_FFFE, 8'hC3, 3'd0, 32'h0, 2'b00);
      repeat (5) send_op(FUNC_POP);
      send_op(FUNC_RESET_TICK);
      send(FUNC_CLEAR_SLOT, 32'h0, 8'h0, 3'd0, 32'h0, 2'b00);
      aim_live[0] = 1'b0;
      send(FUNC_READ, 32'h0000_0000, 8'h11, 3'd0, 32'h0, 2'b00);
      clear_all();
      send_op(FUNC_POP);

      // Random episodes: set slots, aimed accesses, ticks, pops, noise
      flood(40);
      while (requests_sent < 935) begin
         if (!flooded_mid && requests_sent > 500) begin
            flooded_mid = 1'b1;
            flood(36);
         end
         case ($urandom_range(0, 9))
            0:       clear_all();
            1:       send_op(FUNC_RESET_TICK);
            default: ;
         endcase
         repeat ($urandom_range(1, 3)) random_set();
         repeat ($urandom_range(4, 24)) begin
            pick = $urandom_range(0, 99);
            if (pick < 65)
               send($urandom_range(0, 1) ? FUNC_WRITE : FUNC_READ, pick_addr(),
                    VALUE_W'($urandom), SLOT_W'($urandom), $urandom, MODE_W'($urandom));
            else if (pick < 75)
               send_op(FUNC_TICK);
            else if (pick < 90)
               send_op(FUNC_POP);
            else if (pick < 94) begin
               pick = $urandom_range(0, WATCH_SLOTS - 1);
               aim_live[pick] = 1'b0;
               send(FUNC_CLEAR_SLOT, $urandom, VALUE_W'($urandom), SLOT_W'(pick), $urandom,
                    MODE_W'($urandom));
            end else if (pick < 97)
               random_set();
            else
               send(FUNC_W'($urandom), $urandom, VALUE_W'($urandom), SLOT_W'($urandom),
                    $urandom, MODE_W'($urandom));
         end
         repeat ($urandom_range(1, 10)) send_op(FUNC_POP);
      end
      req_valid <= 1'b0;

      // Drain, then keep watching for anything unexpected
      while (pending_count != 0) @(negedge clock);
      repeat (20) @(negedge clock);

      $display("Run covered %0d requests and %0d responses, %0d of them logged hits",
               requests_sent, responses_seen, hits_returned);
      $display("Log overrun replaced %0d unread entries", overwrites);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

FILE: files.f
hw/rtl/mwu_pkg.sv
hw/rtl/mwu_front.sv
hw/rtl/mwu_queue.sv
hw/rtl/mwu_back.sv
hw/rtl/memory_watchpoint_unit_core.sv
hw/rtl/mwu_checker.sv
sim/mwu_hit_checker.sv
sim/tb_memory_watchpoint_unit_core.sv
